FILE: hdl/bsff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsff_pkg
// Shared types and constants of the membership bitmap with find-first search.
// ----------------------------------------------------------------------------
package bsff_pkg;

    // The bit index and the word address together form a value, so WORD_BITS
    // is a power of two.
    localparam int WORD_BITS = 64;
    localparam int CAPACITY  = 1024;
    localparam int NUM_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int VALUE_W   = 10;
    localparam int COUNT_W   = 11;
    localparam int LAST_WORD = NUM_WORDS - 1;
    localparam int TAIL_BITS = CAPACITY - LAST_WORD * WORD_BITS;

    localparam logic [WORD_BITS-1:0] TAIL_MASK =
        {WORD_BITS{1'b1}} >> (WORD_BITS - TAIL_BITS);

    typedef enum logic [2:0] {
        OP_INSERT        = 3'd0,
        OP_REMOVE        = 3'd1,
        OP_QUERY         = 3'd2,
        OP_FIND_MISSING  = 3'd3,
        OP_FIND_EXISTING = 3'd4,
        OP_CLEAR         = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MODIFY,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]         op;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic               status;
        logic               is_member;
        logic [VALUE_W-1:0] found_value;
        logic [COUNT_W-1:0] member_count;
    } t_rsp;

    typedef struct packed {
        logic                 rd_en;
        logic [WADDR_W-1:0]   rd_addr;
        logic                 wr_en;
        logic [WADDR_W-1:0]   wr_addr;
        logic [WORD_BITS-1:0] wr_data;
        logic                 clear;
    } t_ram_req;

endpackage

FILE: hdl/bsff_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsff_ram
// Bitmap word memory with a registered read port and one flag per row; a row
// whose flag is clear reads as zero, which lets reset and clear empty every row at once.
// ----------------------------------------------------------------------------
module bsff_ram import bsff_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ram_req             i_ram,
    output logic [WORD_BITS-1:0] o_rd_data
);

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_row_valid;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_ram.wr_en) begin
            r_mem[i_ram.wr_addr] <= i_ram.wr_data;
        end
        if (i_ram.rd_en) begin
            r_rd_data <= r_mem[i_ram.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_hit    <= 1'b0;
        end else begin
            if (i_ram.clear) begin
                r_row_valid <= '0;
            end else if (i_ram.wr_en) begin
                r_row_valid[i_ram.wr_addr] <= 1'b1;
            end
            if (i_ram.rd_en) begin
                r_rd_hit <= r_row_valid[i_ram.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

FILE: hdl/bitmap_set_find_first.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_set_find_first
// Set of small integers kept as a bitmap in a word memory, with a member
// count, insert, remove, query, clear and upward find-first searches.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Word
//  request   in         i_req_valid / o_req_stall i_req (op, value)
//  response  out        o_rsp_valid / i_rsp_stall o_rsp (status, is_member,
//                                                 found_value, member_count)
//
// One request is handled at a time. Insert, remove and query pass through
// S_MODIFY and then S_DONE before the result reaches the output register,
// clear and invalid operations go straight to S_DONE, and a search stays in
// S_SCAN for each word examined (up to 16) before S_DONE. The memory read is
// registered, and the memory is read one word per cycle during a search.
// Reset clears the row flags at once, so there is no clearing pass.
// A stalled response holds in the output register; the next request is taken
// once the current result has been loaded into it.
// ----------------------------------------------------------------------------
module bitmap_set_find_first import bsff_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    t_state               r_state, n_state;
    logic [2:0]           r_op, n_op;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic [WADDR_W-1:0]   r_word, n_word;
    logic                 r_first, n_first;
    logic [COUNT_W-1:0]   r_count, n_count;
    t_rsp                 r_res, n_res;
    logic                 r_rsp_valid, n_rsp_valid;
    t_rsp                 r_rsp;
    logic                 rsp_load;

    t_ram_req             ram_req;
    logic [WORD_BITS-1:0] rd_data;

    logic                 out_free;
    logic                 req_in_range;
    logic [WADDR_W-1:0]   req_word;
    logic [BIT_W-1:0]     cur_off;
    logic                 cur_bit;
    logic                 last_word;
    logic [WORD_BITS-1:0] scan_mask;
    logic [WORD_BITS-1:0] scan_cand;
    logic                 scan_hit;
    logic [BIT_W-1:0]     scan_idx;
    logic [VALUE_W-1:0]   scan_found;

    bsff_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ram     (ram_req),
        .o_rd_data (rd_data)
    );

    assign out_free     = !r_rsp_valid || !i_rsp_stall;
    assign req_in_range = (32'(i_req.value) < 32'(CAPACITY));
    assign req_word     = WADDR_W'(i_req.value >> BIT_W);
    assign cur_off      = r_value[BIT_W-1:0];
    assign cur_bit      = rd_data[cur_off];
    assign last_word    = (r_word == WADDR_W'(LAST_WORD));

    always_comb begin
        scan_mask = (r_first ? ({WORD_BITS{1'b1}} << cur_off) : {WORD_BITS{1'b1}})
                  & (last_word ? TAIL_MASK : {WORD_BITS{1'b1}});
        scan_cand = ((r_op == OP_FIND_EXISTING) ? rd_data : ~rd_data) & scan_mask;
        scan_hit  = |scan_cand;
        scan_idx  = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (scan_cand[i]) begin
                scan_idx = BIT_W'(i);
            end
        end
        scan_found = VALUE_W'({r_word, scan_idx});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_value <= n_value;
        r_word  <= n_word;
        r_first <= n_first;
        r_res   <= n_res;
        if (rsp_load) begin
            r_rsp <= r_res;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_value     = r_value;
        n_word      = r_word;
        n_first     = r_first;
        n_count     = r_count;
        n_res       = r_res;
        rsp_load    = 1'b0;
        ram_req     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op    = i_req.op;
                    n_value = i_req.value;
                    n_word  = req_word;
                    n_first = 1'b1;
                    n_res   = '{status: 1'b0, is_member: 1'b0, found_value: '0,
                                member_count: r_count};
                    unique case (i_req.op)
                        OP_INSERT, OP_REMOVE, OP_QUERY: begin
                            if (req_in_range) begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = req_word;
                                n_state         = S_MODIFY;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        OP_FIND_MISSING, OP_FIND_EXISTING: begin
                            if (req_in_range) begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = req_word;
                                n_state         = S_SCAN;
                            end else begin
                                n_res.status = 1'b1;
                                n_state      = S_DONE;
                            end
                        end
                        OP_CLEAR: begin
                            ram_req.clear      = 1'b1;
                            n_count            = '0;
                            n_res.member_count = '0;
                            n_state            = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MODIFY: begin
                ram_req.wr_addr = r_word;
                unique case (r_op)
                    OP_INSERT: begin
                        if (!cur_bit) begin
                            ram_req.wr_en   = 1'b1;
                            ram_req.wr_data = rd_data | (WORD_BITS'(1) << cur_off);
                            n_count         = r_count + COUNT_W'(1);
                        end
                    end
                    OP_REMOVE: begin
                        if (cur_bit) begin
                            ram_req.wr_en   = 1'b1;
                            ram_req.wr_data = rd_data & ~(WORD_BITS'(1) << cur_off);
                            n_count         = r_count - COUNT_W'(1);
                        end
                    end
                    default: begin
                        n_res.is_member = cur_bit;
                    end
                endcase
                n_res.member_count = n_count;
                n_state            = S_DONE;
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_res.found_value = scan_found;
                    n_state           = S_DONE;
                end else if (last_word) begin
                    n_res.status = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = r_word + WADDR_W'(1);
                    n_word          = r_word + WADDR_W'(1);
                    n_first         = 1'b0;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    rsp_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rsp_valid = rsp_load || (r_rsp_valid && i_rsp_stall);
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(CAPACITY))
        else $error("member count exceeds capacity");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall && i_req.op == OP_CLEAR)
        |=> (r_state == S_DONE && r_count == '0 && r_res.member_count == '0))
        else $error("clear did not empty the set");

    a_found_above_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && scan_hit) |-> (scan_found >= r_value))
        else $error("search found a value below its start");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_MODIFY && !(i_req_valid && !o_req_stall && i_req.op == OP_CLEAR))
        |=> (r_count == $past(r_count)))
        else $error("member count changed outside insert, remove or clear");

endmodule
